FILE: sv/dct_pkg.sv
`timescale 1ns / 1ps

package dct_pkg;

	// Field and register widths.
	localparam int SPAN_W = 25;
	localparam int OBJ_W  = 32;
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;
	localparam int CFG_AW = 1;
	localparam int CFG_DW = 32;

	// Request codes.
	localparam logic [FUNC_W-1:0] FN_MARK  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] REG_CHUNK_SPAN   = 1'd0;
	localparam logic [CFG_AW-1:0] REG_OBJECT_TOTAL = 1'd1;

	// Full-copy decision works on chunks of 16384 objects.
	localparam int TOTAL_ROUND = 16383;
	localparam int TOTAL_SHIFT = 14;

	localparam logic [SPAN_W-1:0] SPAN_RESET = 25'd16384;

	// Result of each iterative divider.
	typedef struct packed {
		logic             done;
		logic [OBJ_W-1:0]  quot;
		logic [SPAN_W-1:0] rem;
	} div_res_t;

endpackage

FILE: sv/dct_ram.sv
`timescale 1ns / 1ps

module dct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/dct_div.sv
`timescale 1ns / 1ps

module dct_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dct_pkg::OBJ_W-1:0]  num,
	input  logic [dct_pkg::SPAN_W-1:0] den,
	output dct_pkg::div_res_t         res
);
	import dct_pkg::*;

	localparam int STEP_W = $clog2(OBJ_W);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [OBJ_W-1:0]  quot_q;
	logic [SPAN_W-1:0] rem_q;
	logic [SPAN_W:0]   trial;
	logic              fits;

	// One restoring step: shift in the next numerator bit and try the subtract.
	always_comb begin
		trial = {rem_q, quot_q[OBJ_W-1]};
		fits  = (trial >= {1'b0, den});
	end

	// Iterates one quotient bit per cycle and pulses done after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quot_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				quot_q <= num;
				rem_q  <= '0;
			end else if (run_q) begin
				quot_q <= {quot_q[OBJ_W-2:0], fits};
				rem_q  <= fits ? SPAN_W'(trial - {1'b0, den}) : trial[SPAN_W-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(OBJ_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

FILE: sv/dirty_chunk_tracker.sv
`timescale 1ns / 1ps

// Dirty chunk tracker. A transaction is taken when start is high and busy is low;
// its result appears on the result ports for exactly one cycle with done high,
// and the receiver cannot hold it off. A mark transaction runs two 32-step
// divisions in parallel (range start and range end by chunk_span), then walks
// the touched chunks through the dirty-bit memory at one chunk per cycle, and
// skips the walk when none of the touched chunks is inside the table. A clear
// transaction sweeps the dirty-bit memory one entry per cycle. A read
// transaction, and the unused code, go through the region memory's registered
// read port. After reset the same sweep runs over the whole dirty-bit memory
// with busy high; configuration writes are taken at any time but must only be
// issued while the block is idle.
module dirty_chunk_tracker #(
	parameter int MAX_CHUNKS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [dct_pkg::FUNC_W-1:0] func,
	input  logic [dct_pkg::OBJ_W-1:0]  range_start,
	input  logic [dct_pkg::OBJ_W-1:0]  range_end,
	input  logic [dct_pkg::IDX_W-1:0]  entry_index,
	input  logic                       cfg_we,
	input  logic [dct_pkg::CFG_AW-1:0] cfg_index,
	input  logic [dct_pkg::CFG_DW-1:0] cfg_data,
	output logic                       done,
	output logic [dct_pkg::CNT_W-1:0]  newly_marked,
	output logic [dct_pkg::CNT_W-1:0]  dirty_count,
	output logic                       full_copy,
	output logic                       overflow,
	output logic [dct_pkg::IDX_W-1:0]  region_chunk,
	output logic [dct_pkg::OBJ_W-1:0]  region_start,
	output logic [dct_pkg::OBJ_W-1:0]  region_end,
	output logic                       region_valid
);
	import dct_pkg::*;

	localparam int CW       = $clog2(MAX_CHUNKS);
	localparam int FW       = $clog2(MAX_CHUNKS + 1);
	localparam int LAST_W   = OBJ_W + 1;
	localparam int HALF_W   = OBJ_W + 1 - (TOTAL_SHIFT + 1);
	localparam int REGION_W = IDX_W + 2 * OBJ_W;

	localparam logic [CW:0]     CHUNK_LIMIT = (CW + 1)'(MAX_CHUNKS);
	localparam logic [FW-1:0]   FILL_LIMIT  = FW'(MAX_CHUNKS);
	localparam logic [CW-1:0]   SWEEP_LAST  = CW'(MAX_CHUNKS - 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIV,
		ST_WALK,
		ST_CLEAR,
		ST_READ
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SPAN_W-1:0] span_q;
	logic [OBJ_W-1:0]  total_q;
	logic [SPAN_W-1:0] span_eff;

	// Captured request.
	logic [FUNC_W-1:0] func_q;
	logic [OBJ_W-1:0]  rs_q;
	logic [OBJ_W-1:0]  re_q;
	logic [IDX_W-1:0]  idx_q;

	// Walk control and accumulators.
	logic [CW:0]      c_q;
	logic [CW:0]      stop_q;
	logic [OBJ_W-1:0] start_acc_q;
	logic [OBJ_W:0]   end_acc_q;
	logic [CW-1:0]    sweep_q;
	logic [FW-1:0]    fill_q;
	logic [FW-1:0]    newly_q;
	logic             ovf_q;

	// Check stage of the walk, in the cycle after the dirty-bit read is issued.
	logic             v_s1;
	logic [CW-1:0]    c_s1;
	logic [OBJ_W-1:0] start_s1;
	logic [OBJ_W:0]   end_s1;

	// Result registers.
	logic              done_q;
	logic [CNT_W-1:0]  newly_marked_q;
	logic [CNT_W-1:0]  dirty_count_q;
	logic              full_copy_q;
	logic              overflow_q;
	logic [IDX_W-1:0]  region_chunk_q;
	logic [OBJ_W-1:0]  region_start_q;
	logic [OBJ_W-1:0]  region_end_q;
	logic              region_valid_q;

	// Divider and memory connections.
	div_res_t          div_s;
	div_res_t          div_e;
	logic              div_go;
	logic              d_we;
	logic [CW-1:0]     d_waddr;
	logic [0:0]        d_wdata;
	logic [0:0]        d_rdata;
	logic              r_we;
	logic [REGION_W-1:0] r_wdata;
	logic [REGION_W-1:0] r_rdata;
	logic [CW-1:0]     r_raddr;

	// Combinational helpers.
	logic              accept;
	logic [LAST_W-1:0] first_ext;
	logic [LAST_W-1:0] last_ext;
	logic              ovf_now;
	logic [CW:0]       stop_now;
	logic              walk_now;
	logic [OBJ_W-1:0]  base_now;
	logic              issue;
	logic              take;
	logic [OBJ_W-1:0]  clip_end;
	logic [HALF_W-1:0] half_total;
	logic              full_now;
	logic              rvalid_now;

	assign span_eff = (span_q == '0) ? SPAN_W'(1) : span_q;
	assign accept   = start && (state_q == ST_IDLE);
	assign div_go   = accept && (func == FN_MARK);
	assign busy     = (state_q != ST_IDLE);

	// Start and end of the range are divided side by side.
	dct_div u_div_start (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (range_start),
		.den    (span_eff),
		.res    (div_s)
	);

	dct_div u_div_end (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (range_end),
		.den    (span_eff),
		.res    (div_e)
	);

	// Chunk range from the quotients; the chunk base comes from the remainder.
	always_comb begin
		first_ext = LAST_W'(div_s.quot);
		last_ext  = LAST_W'(div_e.quot) + LAST_W'(div_e.rem != '0);
		ovf_now   = (last_ext > first_ext) && (last_ext > LAST_W'(MAX_CHUNKS));
		stop_now  = (last_ext < LAST_W'(MAX_CHUNKS)) ? last_ext[CW:0] : CHUNK_LIMIT;
		walk_now  = first_ext < LAST_W'(stop_now);
		base_now  = rs_q - OBJ_W'(div_s.rem);
	end

	// Walk pipeline: read a dirty bit, then decide and write back next cycle.
	always_comb begin
		issue    = (state_q == ST_WALK) && (c_q < stop_q);
		take     = v_s1 && !d_rdata[0] && (fill_q < FILL_LIMIT);
		clip_end = (end_s1 < {1'b0, re_q}) ? end_s1[OBJ_W-1:0] : re_q;
		r_we     = take;
		r_wdata  = {IDX_W'(c_s1), start_s1, clip_end};
		r_raddr  = (state_q == ST_IDLE) ? CW'(entry_index) : CW'(idx_q);
	end

	// The sweep owns the dirty-bit write port during reset and clear.
	always_comb begin
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			d_we    = 1'b1;
			d_waddr = sweep_q;
			d_wdata = 1'b0;
		end else begin
			d_we    = take;
			d_waddr = c_s1;
			d_wdata = 1'b1;
		end
	end

	// Full copy when the fill exceeds half of the rounded-up chunk total.
	always_comb begin
		half_total = HALF_W'((LAST_W'(total_q) + LAST_W'(TOTAL_ROUND)) >> (TOTAL_SHIFT + 1));
		full_now   = OBJ_W'(fill_q) > OBJ_W'(half_total);
		rvalid_now = (func_q == FN_READ) && (OBJ_W'(idx_q) < OBJ_W'(fill_q));
	end

	dct_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CHUNKS)
	) u_dirty_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (c_q[CW-1:0]),
		.rdata (d_rdata)
	);

	dct_ram #(
		.WIDTH (REGION_W),
		.DEPTH (MAX_CHUNKS)
	) u_region_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (fill_q[CW-1:0]),
		.wdata (r_wdata),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q  <= SPAN_RESET;
			total_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHUNK_SPAN:   span_q  <= cfg_data[SPAN_W-1:0];
				REG_OBJECT_TOTAL: total_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, walk pipeline and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			func_q         <= '0;
			rs_q           <= '0;
			re_q           <= '0;
			idx_q          <= '0;
			c_q            <= '0;
			stop_q         <= '0;
			start_acc_q    <= '0;
			end_acc_q      <= '0;
			sweep_q        <= '0;
			fill_q         <= '0;
			newly_q        <= '0;
			ovf_q          <= 1'b0;
			v_s1           <= 1'b0;
			c_s1           <= '0;
			start_s1       <= '0;
			end_s1         <= '0;
			done_q         <= 1'b0;
			newly_marked_q <= '0;
			dirty_count_q  <= '0;
			full_copy_q    <= 1'b0;
			overflow_q     <= 1'b0;
			region_chunk_q <= '0;
			region_start_q <= '0;
			region_end_q   <= '0;
			region_valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// Advance the read side of the walk.
			v_s1 <= issue;
			if (issue) begin
				c_s1        <= c_q[CW-1:0];
				start_s1    <= start_acc_q;
				end_s1      <= end_acc_q;
				c_q         <= c_q + 1'b1;
				start_acc_q <= start_acc_q + OBJ_W'(span_eff);
				end_acc_q   <= end_acc_q + LAST_W'(span_eff);
			end

			// A newly dirty chunk gets the next region entry.
			if (take) begin
				fill_q  <= fill_q + 1'b1;
				newly_q <= newly_q + 1'b1;
			end

			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SWEEP_LAST) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						func_q  <= func;
						rs_q    <= range_start;
						re_q    <= range_end;
						idx_q   <= entry_index;
						newly_q <= '0;
						ovf_q   <= 1'b0;
						case (func)
							FN_MARK:  state_q <= ST_DIV;
							FN_CLEAR: state_q <= ST_CLEAR;
							default:  state_q <= ST_READ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_s.done) begin
						ovf_q <= ovf_now;
						if (walk_now) begin
							c_q         <= div_s.quot[CW:0];
							stop_q      <= stop_now;
							start_acc_q <= base_now;
							end_acc_q   <= LAST_W'(base_now) + LAST_W'(span_eff);
							state_q     <= ST_WALK;
						end else begin
							done_q         <= 1'b1;
							newly_marked_q <= '0;
							dirty_count_q  <= CNT_W'(fill_q);
							full_copy_q    <= full_now;
							overflow_q     <= ovf_now;
							region_chunk_q <= '0;
							region_start_q <= '0;
							region_end_q   <= '0;
							region_valid_q <= 1'b0;
							state_q        <= ST_IDLE;
						end
					end
				end
				ST_WALK: begin
					if (!issue && !v_s1) begin
						done_q         <= 1'b1;
						newly_marked_q <= CNT_W'(newly_q);
						dirty_count_q  <= CNT_W'(fill_q);
						full_copy_q    <= full_now;
						overflow_q     <= ovf_q;
						region_chunk_q <= '0;
						region_start_q <= '0;
						region_end_q   <= '0;
						region_valid_q <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SWEEP_LAST) begin
						sweep_q        <= '0;
						fill_q         <= '0;
						done_q         <= 1'b1;
						newly_marked_q <= '0;
						dirty_count_q  <= '0;
						full_copy_q    <= 1'b0;
						overflow_q     <= 1'b0;
						region_chunk_q <= '0;
						region_start_q <= '0;
						region_end_q   <= '0;
						region_valid_q <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				ST_READ: begin
					done_q         <= 1'b1;
					newly_marked_q <= '0;
					dirty_count_q  <= CNT_W'(fill_q);
					full_copy_q    <= full_now;
					overflow_q     <= 1'b0;
					region_valid_q <= rvalid_now;
					region_chunk_q <= rvalid_now ? r_rdata[REGION_W-1 -: IDX_W] : '0;
					region_start_q <= rvalid_now ? r_rdata[2*OBJ_W-1 -: OBJ_W] : '0;
					region_end_q   <= rvalid_now ? r_rdata[OBJ_W-1:0] : '0;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign newly_marked = newly_marked_q;
	assign dirty_count  = dirty_count_q;
	assign full_copy    = full_copy_q;
	assign overflow     = overflow_q;
	assign region_chunk = region_chunk_q;
	assign region_start = region_start_q;
	assign region_end   = region_end_q;
	assign region_valid = region_valid_q;

	// The region table never holds more entries than the chunk table.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_LIMIT)
		else $error("region fill beyond table size");

	// Chunks added by the current request are all counted in the fill.
	a_newly_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		newly_q <= fill_q)
		else $error("newly marked count exceeds fill");

	// Results never abut: a done strobe is never directly followed by another.
	a_done_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe on consecutive cycles");

	// A chunk in the check stage only exists while the walk runs.
	a_check_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_WALK))
		else $error("walk check stage active outside the walk");

endmodule
